// ===== src/lfa_pkg.sv =====
// ----------------------------------------------------------------------------
// lfa_pkg: shared types, constants and the flux microprogram
// Widths of the fixed-point datapath, the operation encoding used between
// controller and datapath, and the step program for one face.
// ----------------------------------------------------------------------------
`default_nettype none
package lfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int UWORD     = WORD_BITS - 1;
    localparam int INNER_SH  = 60;
    localparam int VAL_W     = INNER_SH + 2;
    localparam int MAG_W     = INNER_SH + 1;
    localparam int NIB       = 4;
    localparam int MB_W      = 64;
    localparam int MUL_ITERS = MB_W / NIB;
    localparam int ACC_W     = MAG_W + MB_W;
    localparam int DIV_W     = WORD_BITS + FRAC_BITS;
    localparam int SQ_ITERS  = (UWORD + FRAC_BITS + 1) / 2;
    localparam int SQ_W      = 2 * SQ_ITERS;
    localparam int SQR_W     = SQ_ITERS + 3;
    localparam int OUT_W     = 48;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int PC_W      = 6;
    localparam int IN_DATA_W = 288;
    localparam int OUT_DATA_W = 4 * OUT_W;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] w0;
        logic signed [WORD_BITS-1:0] v0;
        logic signed [WORD_BITS-1:0] u0;
        logic        [UWORD-1:0]     rho;
        logic        [UWORD-1:0]     c0sq;
        logic signed [WORD_BITS-1:0] w;
        logic signed [WORD_BITS-1:0] v;
        logic signed [WORD_BITS-1:0] u;
        logic signed [WORD_BITS-1:0] p;
    } side_t;

    typedef enum logic [3:0] {
        OP_SQRT, OP_AMAX, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_HALF, OP_END
    } op_code_t;

    typedef enum logic [4:0] {
        S_LP, S_LU, S_LV, S_LW, S_LC, S_LR, S_LU0, S_LV0, S_LW0,
        S_RP, S_RU, S_RV, S_RW, S_RC, S_RR, S_RU0, S_RV0, S_RW0,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_A, S_ZERO
    } src_t;

    typedef enum logic [3:0] {
        D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7,
        D_A, D_F0, D_F1, D_F2, D_F3, D_NONE
    } dst_t;

    typedef struct packed {
        op_code_t code;
        dst_t     dst;
        src_t     a;
        src_t     b;
    } op_t;

    typedef struct packed {
        logic load_left;
        logic load_right;
        logic clear;
        logic start;
        logic emit;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    // Temps: T2/T3 left pressure/velocity flux, T4/T5 right, T6 jump, T7 sum.
    function automatic op_t prog(input logic [PC_W-1:0] pc);
        op_t o;
        unique case (pc)
            6'd0:  o = '{OP_SQRT, D_T0, S_LC,   S_ZERO};
            6'd1:  o = '{OP_AMAX, D_A,  S_LU0,  S_T0};
            6'd2:  o = '{OP_SQRT, D_T0, S_RC,   S_ZERO};
            6'd3:  o = '{OP_AMAX, D_A,  S_RU0,  S_T0};
            6'd4:  o = '{OP_MUL,  D_T0, S_LR,   S_LC};
            6'd5:  o = '{OP_MUL,  D_T0, S_T0,   S_LU};
            6'd6:  o = '{OP_MUL,  D_T1, S_LP,   S_LU0};
            6'd7:  o = '{OP_ADD,  D_T2, S_T0,   S_T1};
            6'd8:  o = '{OP_DIV,  D_T0, S_LP,   S_LR};
            6'd9:  o = '{OP_MUL,  D_T1, S_LU0,  S_LU};
            6'd10: o = '{OP_ADD,  D_T0, S_T0,   S_T1};
            6'd11: o = '{OP_MUL,  D_T1, S_LV0,  S_LV};
            6'd12: o = '{OP_ADD,  D_T0, S_T0,   S_T1};
            6'd13: o = '{OP_MUL,  D_T1, S_LW0,  S_LW};
            6'd14: o = '{OP_ADD,  D_T3, S_T0,   S_T1};
            6'd15: o = '{OP_MUL,  D_T0, S_RR,   S_RC};
            6'd16: o = '{OP_MUL,  D_T0, S_T0,   S_RU};
            6'd17: o = '{OP_MUL,  D_T1, S_RP,   S_RU0};
            6'd18: o = '{OP_ADD,  D_T4, S_T0,   S_T1};
            6'd19: o = '{OP_DIV,  D_T0, S_RP,   S_RR};
            6'd20: o = '{OP_MUL,  D_T1, S_RU0,  S_RU};
            6'd21: o = '{OP_ADD,  D_T0, S_T0,   S_T1};
            6'd22: o = '{OP_MUL,  D_T1, S_RV0,  S_RV};
            6'd23: o = '{OP_ADD,  D_T0, S_T0,   S_T1};
            6'd24: o = '{OP_MUL,  D_T1, S_RW0,  S_RW};
            6'd25: o = '{OP_ADD,  D_T5, S_T0,   S_T1};
            6'd26: o = '{OP_SUB,  D_T6, S_RP,   S_LP};
            6'd27: o = '{OP_ADD,  D_T7, S_T2,   S_T4};
            6'd28: o = '{OP_MUL,  D_T1, S_A,    S_T6};
            6'd29: o = '{OP_SUB,  D_T7, S_T7,   S_T1};
            6'd30: o = '{OP_HALF, D_F0, S_T7,   S_ZERO};
            6'd31: o = '{OP_SUB,  D_T6, S_RU,   S_LU};
            6'd32: o = '{OP_ADD,  D_T7, S_T3,   S_T5};
            6'd33: o = '{OP_MUL,  D_T1, S_A,    S_T6};
            6'd34: o = '{OP_SUB,  D_T7, S_T7,   S_T1};
            6'd35: o = '{OP_HALF, D_F1, S_T7,   S_ZERO};
            6'd36: o = '{OP_SUB,  D_T6, S_RV,   S_LV};
            6'd37: o = '{OP_MUL,  D_T1, S_A,    S_T6};
            6'd38: o = '{OP_SUB,  D_T7, S_ZERO, S_T1};
            6'd39: o = '{OP_HALF, D_F2, S_T7,   S_ZERO};
            6'd40: o = '{OP_SUB,  D_T6, S_RW,   S_LW};
            6'd41: o = '{OP_MUL,  D_T1, S_A,    S_T6};
            6'd42: o = '{OP_SUB,  D_T7, S_ZERO, S_T1};
            6'd43: o = '{OP_HALF, D_F3, S_T7,   S_ZERO};
            default: o = '{OP_END, D_NONE, S_ZERO, S_ZERO};
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== src/lax_friedrichs_acoustic_flux_core.sv =====
// ----------------------------------------------------------------------------
// lax_friedrichs_acoustic_flux_core: Lax-Friedrichs face flux, acoustics
// Top level joining the controller and the fixed-point datapath.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream. s_tuser is the mode: an item with mode 0 is
// stored as the left side of a face and produces nothing; an item with mode 1
// is the right side and produces one result on the m_ stream, computed from
// the stored left side and this item. The left side is kept afterwards.
// A left-side item is stored directly. A right-side item runs a program of
// 44 steps on one shared arithmetic unit: sixteen 4-bit-per-cycle multiplies,
// two 48-step restoring divisions, two 24-step square roots and 24 single-step
// adds. No new item is taken until the result of the face has been handed to
// the output register.
// The result sits in an output register, so a stalled receiver does not stop
// the block: it accepts and computes the next face and only waits if that
// result is ready while the previous one is still unread.
// After reset the left side is all zeros with a base density of one raw LSB,
// and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none
module lax_friedrichs_acoustic_flux_core import lfa_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pressure, vel_x, vel_y, vel_z, sound_speed_sq, base_density,
    // base_vel_x, base_vel_y, base_vel_z, zero padding
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // mode
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pressure_flux, xvel_flux, yvel_flux, zvel_flux
    output logic [OUT_DATA_W-1:0]       m_tdata,
    // saturated
    output logic                        m_tuser
);

    ctrl_cmd_t cmd;
    dp_stat_t stat;
    side_t in_side;

    // Unpack the item; a zero base density is taken as one raw LSB.
    always_comb begin
        in_side.p    = s_tdata[31:0];
        in_side.u    = s_tdata[63:32];
        in_side.v    = s_tdata[95:64];
        in_side.w    = s_tdata[127:96];
        in_side.c0sq = s_tdata[158:128];
        in_side.rho  = (s_tdata[189:159] == '0) ? UWORD'(1) : s_tdata[189:159];
        in_side.u0   = s_tdata[221:190];
        in_side.v0   = s_tdata[253:222];
        in_side.w0   = s_tdata[285:254];
    end

    lfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    lfa_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_side  (in_side),
        .stat     (stat),
        .res_data (m_tdata),
        .res_flag (m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/lfa_dpath.sv =====
// ----------------------------------------------------------------------------
// lfa_dpath: flux datapath
// Side registers, temporaries and one shared unit that multiplies, divides,
// takes square roots and does the clipped adds, one operation per command.
// ----------------------------------------------------------------------------
`default_nettype none
module lfa_dpath import lfa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    input  wire side_t                 in_side,
    output dp_stat_t                   stat,
    output logic [OUT_DATA_W-1:0]      res_data,
    output logic                       res_flag
);

    typedef enum logic [1:0] {DP_IDLE, DP_PREP, DP_ITER, DP_FIN} dp_phase_t;

    localparam logic signed [VAL_W:0] LIM_S  = (VAL_W+1)'(1) << INNER_SH;
    localparam logic signed [ACC_W:0] LIM_P  = (ACC_W+1)'(1) << INNER_SH;
    localparam logic signed [VAL_W-1:0] LIM_V = VAL_W'(1) << INNER_SH;
    localparam logic signed [VAL_W-1:0] OMAX  = (VAL_W'(1) << (OUT_W-1)) - VAL_W'(1);
    localparam logic signed [VAL_W-1:0] OMIN  = -(VAL_W'(1) << (OUT_W-1));
    // Reset left side: all zeros with the density word at one raw LSB.
    localparam side_t LEFT_RST = side_t'($bits(side_t)'(1) << (4*WORD_BITS + UWORD));

    side_t left_reg, right_reg;
    logic signed [VAL_W-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic signed [VAL_W-1:0] amax_reg, a_reg, b_reg;
    logic [OUT_W-1:0] f0_reg, f1_reg, f2_reg, f3_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic out_flag_reg, flag_reg, done_reg, neg_reg;
    op_t op_reg;
    dp_phase_t phase_reg;
    logic [CNT_W-1:0] it_reg;
    logic [MAG_W-1:0] ma_reg;
    logic [MB_W-1:0] mb_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [DIV_W-1:0] num_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [SQ_W-1:0] rad_reg;
    logic [SQ_ITERS-1:0] root_reg;
    logic [SQR_W-1:0] srem_reg;

    function automatic logic signed [VAL_W-1:0] sel(input src_t s);
        logic signed [VAL_W-1:0] v;
        unique case (s)
            S_LP:  v = VAL_W'(left_reg.p);
            S_LU:  v = VAL_W'(left_reg.u);
            S_LV:  v = VAL_W'(left_reg.v);
            S_LW:  v = VAL_W'(left_reg.w);
            S_LC:  v = VAL_W'(left_reg.c0sq);
            S_LR:  v = VAL_W'(left_reg.rho);
            S_LU0: v = VAL_W'(left_reg.u0);
            S_LV0: v = VAL_W'(left_reg.v0);
            S_LW0: v = VAL_W'(left_reg.w0);
            S_RP:  v = VAL_W'(right_reg.p);
            S_RU:  v = VAL_W'(right_reg.u);
            S_RV:  v = VAL_W'(right_reg.v);
            S_RW:  v = VAL_W'(right_reg.w);
            S_RC:  v = VAL_W'(right_reg.c0sq);
            S_RR:  v = VAL_W'(right_reg.rho);
            S_RU0: v = VAL_W'(right_reg.u0);
            S_RV0: v = VAL_W'(right_reg.v0);
            S_RW0: v = VAL_W'(right_reg.w0);
            S_T0:  v = t0_reg;
            S_T1:  v = t1_reg;
            S_T2:  v = t2_reg;
            S_T3:  v = t3_reg;
            S_T4:  v = t4_reg;
            S_T5:  v = t5_reg;
            S_T6:  v = t6_reg;
            S_T7:  v = t7_reg;
            S_A:   v = amax_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic signed [VAL_W:0] sum_s, dif_s, sd_s;
    logic signed [VAL_W-1:0] abs_a, abs_b, abs_sum, abs_dif, half_v;
    logic signed [ACC_W:0] prod_s, q_s;
    logic [WORD_BITS:0] dt;
    logic [SQR_W-1:0] st, trial;
    logic [CNT_W-1:0] iters;
    logic wr_en, wr_flag;
    logic signed [VAL_W-1:0] wr_val, qv;
    logic mul_ovf;
    logic signed [VAL_W-1:0] mul_res;

    always_comb begin
        abs_a = a_reg[VAL_W-1] ? -a_reg : a_reg;
        abs_b = b_reg[VAL_W-1] ? -b_reg : b_reg;
        sum_s = (VAL_W+1)'(a_reg) + (VAL_W+1)'(b_reg);
        dif_s = (VAL_W+1)'(a_reg) - (VAL_W+1)'(b_reg);
        sd_s = (op_reg.code == OP_ADD) ? sum_s : dif_s;
        abs_sum = sum_s[VAL_W] ? VAL_W'(-sum_s) : VAL_W'(sum_s);
        abs_dif = dif_s[VAL_W] ? VAL_W'(-dif_s) : VAL_W'(dif_s);
        half_v = a_reg >>> 1;
        prod_s = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        q_s = prod_s >>> FRAC_BITS;
        mul_ovf = (q_s > LIM_P) || (q_s < -LIM_P);
        if (q_s > LIM_P) begin
            mul_res = LIM_V;
        end else if (q_s < -LIM_P) begin
            mul_res = -LIM_V;
        end else begin
            mul_res = VAL_W'(q_s);
        end
        dt = {rem_reg, num_reg[DIV_W-1]};
        st = {srem_reg[SQR_W-3:0], rad_reg[SQ_W-1 -: 2]};
        trial = SQR_W'({root_reg, 2'b01});
        qv = VAL_W'(num_reg);
        unique case (op_reg.code)
            OP_MUL:  iters = CNT_W'(MUL_ITERS - 1);
            OP_DIV:  iters = CNT_W'(DIV_W - 1);
            default: iters = CNT_W'(SQ_ITERS - 1);
        endcase

        wr_en = 1'b0;
        wr_flag = 1'b0;
        wr_val = '0;
        if (phase_reg == DP_PREP) begin
            unique case (op_reg.code)
                OP_ADD, OP_SUB: begin
                    wr_en = 1'b1;
                    wr_flag = (sd_s > LIM_S) || (sd_s < -LIM_S);
                    if (sd_s > LIM_S) begin
                        wr_val = LIM_V;
                    end else if (sd_s < -LIM_S) begin
                        wr_val = -LIM_V;
                    end else begin
                        wr_val = VAL_W'(sd_s);
                    end
                end
                OP_AMAX: begin
                    wr_en = 1'b1;
                    wr_val = amax_reg;
                    if (abs_dif > wr_val) begin
                        wr_val = abs_dif;
                    end
                    if (abs_sum > wr_val) begin
                        wr_val = abs_sum;
                    end
                end
                OP_HALF: begin
                    wr_en = 1'b1;
                    wr_flag = (half_v > OMAX) || (half_v < OMIN);
                    if (half_v > OMAX) begin
                        wr_val = OMAX;
                    end else if (half_v < OMIN) begin
                        wr_val = OMIN;
                    end else begin
                        wr_val = half_v;
                    end
                end
                default: ;
            endcase
        end else if (phase_reg == DP_FIN) begin
            wr_en = 1'b1;
            unique case (op_reg.code)
                OP_MUL: begin
                    wr_flag = mul_ovf;
                    wr_val = mul_res;
                end
                OP_DIV:  wr_val = neg_reg ? -qv : qv;
                default: wr_val = VAL_W'(root_reg);
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DP_IDLE;
            done_reg <= 1'b0;
            left_reg <= LEFT_RST;
        end else begin
            done_reg <= 1'b0;
            if (cmd.load_left) begin
                left_reg <= in_side;
            end
            unique case (phase_reg)
                DP_IDLE: begin
                    if (cmd.start) begin
                        phase_reg <= DP_PREP;
                    end
                end
                DP_PREP: begin
                    if (op_reg.code == OP_MUL || op_reg.code == OP_DIV ||
                        op_reg.code == OP_SQRT) begin
                        phase_reg <= DP_ITER;
                    end else begin
                        phase_reg <= DP_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                DP_ITER: begin
                    if (it_reg == iters) begin
                        phase_reg <= DP_FIN;
                    end
                end
                DP_FIN: begin
                    phase_reg <= DP_IDLE;
                    done_reg <= 1'b1;
                end
                default: phase_reg <= DP_IDLE;
            endcase
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_right) begin
            right_reg <= in_side;
        end
        if (cmd.clear) begin
            amax_reg <= '0;
            flag_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_data_reg <= {f3_reg, f2_reg, f1_reg, f0_reg};
            out_flag_reg <= flag_reg;
        end
        if (phase_reg == DP_IDLE && cmd.start) begin
            op_reg <= cmd.op;
            a_reg <= sel(cmd.op.a);
            b_reg <= sel(cmd.op.b);
        end
        if (phase_reg == DP_PREP) begin
            it_reg <= '0;
            neg_reg <= (op_reg.code == OP_MUL) ? (a_reg[VAL_W-1] != b_reg[VAL_W-1])
                                               : a_reg[VAL_W-1];
            ma_reg <= abs_a[MAG_W-1:0];
            mb_reg <= MB_W'(abs_b[MAG_W-1:0]);
            acc_reg <= '0;
            num_reg <= DIV_W'(abs_a[WORD_BITS-1:0]) << FRAC_BITS;
            rem_reg <= '0;
            rad_reg <= SQ_W'(a_reg[UWORD-1:0]) << FRAC_BITS;
            root_reg <= '0;
            srem_reg <= '0;
        end
        if (phase_reg == DP_ITER) begin
            it_reg <= it_reg + CNT_W'(1);
            unique case (op_reg.code)
                OP_MUL: begin
                    acc_reg <= (acc_reg << NIB) +
                               ACC_W'(ma_reg * mb_reg[MB_W-1 -: NIB]);
                    mb_reg <= mb_reg << NIB;
                end
                OP_DIV: begin
                    if (dt >= (WORD_BITS+1)'(b_reg[UWORD-1:0])) begin
                        rem_reg <= WORD_BITS'(dt - (WORD_BITS+1)'(b_reg[UWORD-1:0]));
                        num_reg <= {num_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= dt[WORD_BITS-1:0];
                        num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                    end
                end
                default: begin
                    rad_reg <= rad_reg << 2;
                    if (st >= trial) begin
                        srem_reg <= st - trial;
                        root_reg <= {root_reg[SQ_ITERS-2:0], 1'b1};
                    end else begin
                        srem_reg <= st;
                        root_reg <= {root_reg[SQ_ITERS-2:0], 1'b0};
                    end
                end
            endcase
        end
        if (wr_en) begin
            if (wr_flag) begin
                flag_reg <= 1'b1;
            end
            unique case (op_reg.dst)
                D_T0: t0_reg <= wr_val;
                D_T1: t1_reg <= wr_val;
                D_T2: t2_reg <= wr_val;
                D_T3: t3_reg <= wr_val;
                D_T4: t4_reg <= wr_val;
                D_T5: t5_reg <= wr_val;
                D_T6: t6_reg <= wr_val;
                D_T7: t7_reg <= wr_val;
                D_A:  amax_reg <= wr_val;
                D_F0: f0_reg <= wr_val[OUT_W-1:0];
                D_F1: f1_reg <= wr_val[OUT_W-1:0];
                D_F2: f2_reg <= wr_val[OUT_W-1:0];
                D_F3: f3_reg <= wr_val[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign stat.done = done_reg;
    assign res_data = out_data_reg;
    assign res_flag = out_flag_reg;

endmodule
`default_nettype wire

// ===== src/lfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfa_ctrl: flux controller
// Accepts items, steps the datapath through the face program and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lfa_ctrl import lfa_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire logic      mode,
    input  wire logic      m_tready,
    input  wire dp_stat_t  stat,
    output logic           s_tready,
    output logic           m_tvalid,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_EMIT} state_t;

    state_t state_reg;
    logic [PC_W-1:0] pc_reg;
    logic m_tvalid_reg;
    logic accept;

    always_comb begin
        accept = s_tvalid && (state_reg == C_IDLE);
        cmd.load_left = accept && !mode;
        cmd.load_right = accept && mode;
        cmd.clear = accept && mode;
        cmd.op = prog(pc_reg);
        cmd.start = (state_reg == C_ISSUE) && (cmd.op.code != OP_END);
        cmd.emit = (state_reg == C_EMIT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            pc_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                C_IDLE: begin
                    if (accept && mode) begin
                        pc_reg <= '0;
                        state_reg <= C_ISSUE;
                    end
                end
                C_ISSUE: begin
                    state_reg <= (cmd.op.code == OP_END) ? C_EMIT : C_WAIT;
                end
                C_WAIT: begin
                    if (stat.done) begin
                        pc_reg <= pc_reg + PC_W'(1);
                        state_reg <= C_ISSUE;
                    end
                end
                C_EMIT: begin
                    if (cmd.emit) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == C_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire
